FILE: design/c2d_pkg.sv
// Shared constants, types and codes of the 2D convolution block.
package c2d_pkg;

  localparam int unsigned KDIM        = 5;
  localparam int unsigned MAX_WIDTH   = 64;
  localparam int unsigned LINES       = KDIM - 1;
  localparam int unsigned TAPS        = KDIM * KDIM;
  localparam int unsigned ADDR_W      = $clog2(MAX_WIDTH);

  localparam int unsigned IMG_WIDTH_W  = 7;
  localparam int unsigned IMG_HEIGHT_W = 12;
  localparam int unsigned BIAS_W       = 29;
  localparam int unsigned CFG_DATA_W   = 29;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned WIDX_W   = 5;
  localparam int unsigned PROD_W   = PIX_W + WGT_W + 1;
  localparam int unsigned ROWSUM_W = PROD_W + $clog2(KDIM);
  localparam int unsigned ACC_W    = 33;
  localparam int unsigned VAL_W    = 31;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned COL_W    = 6;

  // operation codes
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [WGT_W-1:0] weight_t;
  typedef pixel_t  [KDIM-1:0][KDIM-1:0] window_t;
  typedef weight_t [KDIM-1:0][KDIM-1:0] kernel_t;
  typedef logic [LINES*PIX_W-1:0] line_word_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pix_meta_t;

endpackage

FILE: design/c2d_if.sv
// Stream interfaces for input items and result items.
interface c2d_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [c2d_pkg::WIDX_W-1:0]  weight_index;
  logic signed [c2d_pkg::WGT_W-1:0] weight_value;
  logic [c2d_pkg::PIX_W-1:0]   pixel;

  modport source (output valid, operation, weight_index, weight_value, pixel,
                  input ready);
  modport sink (input valid, operation, weight_index, weight_value, pixel,
                output ready);
endinterface

interface c2d_out_if;
  logic                       valid;
  logic                       ready;
  logic [c2d_pkg::VAL_W-1:0]  conv_value;
  logic [c2d_pkg::ROW_W-1:0]  out_row;
  logic [c2d_pkg::COL_W-1:0]  out_col;
  logic                       last;

  modport source (output valid, conv_value, out_row, out_col, last, input ready);
  modport sink (input valid, conv_value, out_row, out_col, last, output ready);
endinterface

FILE: design/c2d_line_buf.sv
// Line buffer memory: one word per column holds that column of all buffered lines.
module c2d_line_buf (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [c2d_pkg::ADDR_W-1:0]  rd_addr_i,
  output c2d_pkg::line_word_t         rd_data_o,
  input  logic                        wr_en_i,
  input  logic [c2d_pkg::ADDR_W-1:0]  wr_addr_i,
  input  c2d_pkg::line_word_t         wr_data_i
);

  c2d_pkg::line_word_t mem [c2d_pkg::MAX_WIDTH];
  c2d_pkg::line_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/c2d_front.sv
// Input stage, pixel counters, line buffers, sliding window and kernel store.
module c2d_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  c2d_in_if.sink                           in_i,
  input  logic [c2d_pkg::IMG_WIDTH_W-1:0]  image_width_i,
  input  logic [c2d_pkg::IMG_HEIGHT_W-1:0] image_height_i,
  input  logic                             take_i,
  output c2d_pkg::pix_meta_t               meta_o,
  output c2d_pkg::window_t                 window_o,
  output c2d_pkg::kernel_t                 kernel_o
);

  localparam int unsigned K = c2d_pkg::KDIM;
  localparam int unsigned L = c2d_pkg::LINES;
  localparam int unsigned AW = c2d_pkg::ADDR_W;
  localparam int unsigned RW = c2d_pkg::ROW_W;
  localparam int unsigned PW = c2d_pkg::PIX_W;

  // effective frame size
  logic [c2d_pkg::IMG_WIDTH_W-1:0]  w_eff;
  logic [c2d_pkg::IMG_HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (image_width_i < c2d_pkg::IMG_WIDTH_W'(K)) begin
      w_eff = c2d_pkg::IMG_WIDTH_W'(K);
    end else if (image_width_i > c2d_pkg::IMG_WIDTH_W'(c2d_pkg::MAX_WIDTH)) begin
      w_eff = c2d_pkg::IMG_WIDTH_W'(c2d_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width_i;
    end
    if (image_height_i < c2d_pkg::IMG_HEIGHT_W'(K)) begin
      h_eff = c2d_pkg::IMG_HEIGHT_W'(K);
    end else begin
      h_eff = image_height_i;
    end
  end

  // counters
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          ends_row, ends_frame, produce;

  assign col_inc    = {1'b0, col_q} + (AW+1)'(1);
  assign row_inc    = {1'b0, row_q} + (RW+1)'(1);
  assign ends_row   = col_inc >= (AW+1)'(w_eff);
  assign ends_frame = ends_row && (row_inc >= (RW+1)'(h_eff));
  assign produce    = (row_q >= RW'(L)) && (col_q >= AW'(L));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (ends_row) begin
      col_d = '0;
      row_d = ends_frame ? '0 : row_inc[RW-1:0];
    end else begin
      col_d = col_inc[AW-1:0];
    end
  end

  // handshake
  logic s1_valid_q, meta_valid_q, en1, en2, accept, s1_go, is_pix;

  assign en2        = !meta_valid_q || take_i;
  assign en1        = !s1_valid_q || en2;
  assign in_i.ready = en1;
  assign accept     = in_i.valid && en1;
  assign is_pix     = in_i.operation == c2d_pkg::OP_PIXEL;
  assign s1_go      = s1_valid_q && en2;

  // stage 1 registers
  logic                        op1_q;
  logic [c2d_pkg::WIDX_W-1:0]  widx1_q;
  c2d_pkg::weight_t            wval1_q;
  c2d_pkg::pixel_t             pix1_q;
  logic [AW-1:0]               col1_q;
  logic                        produce1_q;
  logic                        last1_q;
  logic [RW-1:0]               orow1_q;
  logic [c2d_pkg::COL_W-1:0]   ocol1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      if (en1) begin
        s1_valid_q <= accept;
      end
      if (accept && is_pix) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op1_q      <= in_i.operation;
      widx1_q    <= in_i.weight_index;
      wval1_q    <= in_i.weight_value;
      pix1_q     <= in_i.pixel;
      col1_q     <= col_q;
      produce1_q <= produce;
      last1_q    <= ends_frame;
      orow1_q    <= row_q - RW'(L);
      ocol1_q    <= c2d_pkg::COL_W'(col_q - AW'(L));
    end
  end

  // line buffers: the column moves up one line, the pixel enters at the bottom
  c2d_pkg::line_word_t rd_word, wr_word;
  logic                pix_go;

  assign pix_go = s1_go && (op1_q == c2d_pkg::OP_PIXEL);

  always_comb begin
    wr_word = rd_word;
    for (int i = 0; i < int'(L) - 1; i++) begin
      wr_word[i*PW +: PW] = rd_word[(i+1)*PW +: PW];
    end
    wr_word[(L-1)*PW +: PW] = pix1_q;
  end

  c2d_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept && is_pix),
    .rd_addr_i (col_q),
    .rd_data_o (rd_word),
    .wr_en_i   (pix_go),
    .wr_addr_i (col1_q),
    .wr_data_i (wr_word)
  );

  // sliding window
  c2d_pkg::window_t window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (pix_go) begin
      for (int ky = 0; ky < int'(K); ky++) begin
        for (int kx = 0; kx < int'(K) - 1; kx++) begin
          window_q[ky][kx] <= window_q[ky][kx+1];
        end
      end
      for (int i = 0; i < int'(L); i++) begin
        window_q[i][K-1] <= rd_word[i*PW +: PW];
      end
      window_q[K-1][K-1] <= pix1_q;
    end
  end

  // kernel store; indexes past the last tap are dropped
  c2d_pkg::kernel_t kernel_q;

  always_ff @(posedge clk_i) begin
    if (s1_go && (op1_q == c2d_pkg::OP_WEIGHT)) begin
      for (int ky = 0; ky < int'(K); ky++) begin
        for (int kx = 0; kx < int'(K); kx++) begin
          if (widx1_q == c2d_pkg::WIDX_W'(ky*int'(K) + kx)) begin
            kernel_q[ky][kx] <= wval1_q;
          end
        end
      end
    end
  end

  // stage 2: pixel whose window is complete
  logic [RW-1:0]             meta_row_q;
  logic [c2d_pkg::COL_W-1:0] meta_col_q;
  logic                      meta_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_valid_q <= 1'b0;
    end else if (en2) begin
      meta_valid_q <= pix_go && produce1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      meta_row_q  <= orow1_q;
      meta_col_q  <= ocol1_q;
      meta_last_q <= last1_q;
    end
  end

  assign meta_o   = {meta_valid_q, meta_row_q, meta_col_q, meta_last_q};
  assign window_o = window_q;
  assign kernel_o = kernel_q;

endmodule

FILE: design/c2d_mac.sv
// Products, row sums, bias, ReLU and saturation, and the result register.
module c2d_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  c2d_pkg::pix_meta_t          meta_i,
  input  c2d_pkg::window_t            window_i,
  input  c2d_pkg::kernel_t            kernel_i,
  input  logic signed [c2d_pkg::BIAS_W-1:0] bias_i,
  output logic                        take_o,
  c2d_out_if.source                   out_o
);

  localparam int unsigned K  = c2d_pkg::KDIM;
  localparam int unsigned AW = c2d_pkg::ACC_W;
  localparam logic [c2d_pkg::VAL_W-1:0] VAL_MAX = '1;

  logic                      v3_q, v4_q, v5_q, en3, en4, en5;
  logic [c2d_pkg::ROW_W-1:0] row3_q, row4_q;
  logic [c2d_pkg::COL_W-1:0] col3_q, col4_q;
  logic                      last3_q, last4_q;

  assign en5    = !v5_q || out_o.ready;
  assign en4    = !v4_q || en5;
  assign en3    = !v3_q || en4;
  assign take_o = en3;

  // stage 3: one product per tap
  logic signed [c2d_pkg::PROD_W-1:0] prod_d [K][K];
  logic signed [c2d_pkg::PROD_W-1:0] prod_q [K][K];

  always_comb begin
    for (int ky = 0; ky < int'(K); ky++) begin
      for (int kx = 0; kx < int'(K); kx++) begin
        prod_d[ky][kx] = $signed({1'b0, window_i[ky][kx]}) * $signed(kernel_i[ky][kx]);
      end
    end
  end

  // stage 4: one sum per kernel row
  logic signed [c2d_pkg::ROWSUM_W-1:0] rsum_d [K];
  logic signed [c2d_pkg::ROWSUM_W-1:0] rsum_q [K];

  always_comb begin
    for (int ky = 0; ky < int'(K); ky++) begin
      rsum_d[ky] = '0;
      for (int kx = 0; kx < int'(K); kx++) begin
        rsum_d[ky] = rsum_d[ky] + c2d_pkg::ROWSUM_W'(prod_q[ky][kx]);
      end
    end
  end

  // stage 5: total, bias, clamp
  logic signed [AW-1:0]             acc;
  logic [c2d_pkg::VAL_W-1:0]        val_d;

  always_comb begin
    acc = AW'(bias_i);
    for (int ky = 0; ky < int'(K); ky++) begin
      acc = acc + AW'(rsum_q[ky]);
    end
    if (acc < 0) begin
      val_d = '0;
    end else if (acc > $signed({{(AW-c2d_pkg::VAL_W){1'b0}}, VAL_MAX})) begin
      val_d = VAL_MAX;
    end else begin
      val_d = acc[c2d_pkg::VAL_W-1:0];
    end
  end

  logic [c2d_pkg::VAL_W-1:0] val_q;
  logic [c2d_pkg::ROW_W-1:0] row_q;
  logic [c2d_pkg::COL_W-1:0] col_q;
  logic                      last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= meta_i.valid;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && meta_i.valid) begin
      prod_q  <= prod_d;
      row3_q  <= meta_i.row;
      col3_q  <= meta_i.col;
      last3_q <= meta_i.last;
    end
    if (en4 && v3_q) begin
      rsum_q  <= rsum_d;
      row4_q  <= row3_q;
      col4_q  <= col3_q;
      last4_q <= last3_q;
    end
    if (en5 && v4_q) begin
      val_q  <= val_d;
      row_q  <= row4_q;
      col_q  <= col4_q;
      last_q <= last4_q;
    end
  end

  assign out_o.valid      = v5_q;
  assign out_o.conv_value = val_q;
  assign out_o.out_row    = row_q;
  assign out_o.out_col    = col_q;
  assign out_o.last       = last_q;

endmodule

FILE: design/conv2d_valid_bias_relu.sv
// 5x5 valid convolution with bias and ReLU over a raster pixel stream.
// Each pixel passes the input, window, product, row sum and result registers in turn.
// Throughput: one item per cycle while the output is ready; every stage holds independently under stall.
// The line buffer memory (one read and one write port) limits the rate to one pixel.
// Reset clears counters, window, pipeline valids and config (width 28, height 28,
// bias 0); kernel weights and line buffers are not cleared and need no pass.
module conv2d_valid_bias_relu (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  c2d_in_if.sink                          in_i,
  c2d_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [c2d_pkg::IMG_WIDTH_W-1:0]  width_q;
  logic [c2d_pkg::IMG_HEIGHT_W-1:0] height_q;
  logic signed [c2d_pkg::BIAS_W-1:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= c2d_pkg::IMG_WIDTH_W'(28);
      height_q <= c2d_pkg::IMG_HEIGHT_W'(28);
      bias_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c2d_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[c2d_pkg::IMG_WIDTH_W-1:0];
        c2d_pkg::CFG_HEIGHT: height_q <= cfg_data_i[c2d_pkg::IMG_HEIGHT_W-1:0];
        c2d_pkg::CFG_BIAS:   bias_q   <= $signed(cfg_data_i[c2d_pkg::BIAS_W-1:0]);
        default: ;
      endcase
    end
  end

  c2d_pkg::pix_meta_t meta;
  c2d_pkg::window_t   window;
  c2d_pkg::kernel_t   kernel;
  logic               take;

  c2d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .take_i         (take),
    .meta_o         (meta),
    .window_o       (window),
    .kernel_o       (kernel)
  );

  c2d_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .meta_i   (meta),
    .window_i (window),
    .kernel_i (kernel),
    .bias_i   (bias_q),
    .take_o   (take),
    .out_o    (out_o)
  );

endmodule

FILE: dv/conv2d_valid_bias_relu_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 5x5 valid convolution with bias and ReLU.
module conv2d_valid_bias_relu_tb;

  localparam int unsigned KDIM         = c2d_pkg::KDIM;
  localparam int unsigned LINES        = c2d_pkg::LINES;
  localparam int unsigned TAPS         = c2d_pkg::TAPS;
  localparam int unsigned MAX_WIDTH    = c2d_pkg::MAX_WIDTH;
  localparam int unsigned WIDX_W       = c2d_pkg::WIDX_W;
  localparam int unsigned WGT_W        = c2d_pkg::WGT_W;
  localparam int unsigned VAL_W        = c2d_pkg::VAL_W;
  localparam int unsigned ROW_W        = c2d_pkg::ROW_W;
  localparam int unsigned COL_W        = c2d_pkg::COL_W;
  localparam int unsigned CFG_IDX_W    = c2d_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W   = c2d_pkg::CFG_DATA_W;
  localparam int unsigned IMG_WIDTH_W  = c2d_pkg::IMG_WIDTH_W;
  localparam int unsigned IMG_HEIGHT_W = c2d_pkg::IMG_HEIGHT_W;
  localparam int unsigned BIAS_W       = c2d_pkg::BIAS_W;
  localparam int          N_ITEMS      = 1800;

  typedef struct {
    logic              op;
    logic [WIDX_W-1:0] widx;
    logic [WGT_W-1:0]  wval;
    c2d_pkg::pixel_t   pix;
  } stim_item_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } conv_result_t;

  typedef enum {KERN_MAX, KERN_MIN, KERN_RAND} kern_fill_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  c2d_in_if  in_bus ();
  c2d_out_if out_bus ();

  conv2d_valid_bias_relu uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic signed [WGT_W-1:0] kern_w [TAPS] = '{default: '0};
  c2d_pkg::pixel_t line_mem [LINES][MAX_WIDTH] = '{default: '0};
  c2d_pkg::pixel_t win [KDIM][KDIM] = '{default: '0};
  int unsigned row_cnt = 0;
  int unsigned col_cnt = 0;
  logic [IMG_WIDTH_W-1:0]   cfg_width  = 7'd28;
  logic [IMG_HEIGHT_W-1:0]  cfg_height = 12'd28;
  logic signed [BIAS_W-1:0] cfg_bias   = '0;

  conv_result_t conv_q [$];
  stim_item_t   item_q [$];
  stim_item_t   cur_item;
  int           n_given    = 0;
  int           n_taken    = 0;
  bit           no_idle    = 1'b0;
  int           err_count  = 0;
  int           items_sent = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w < KDIM) w = KDIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = cfg_height;
    if (h < KDIM) h = KDIM;
    return h;
  endfunction

  // pixels still needed to close the current frame
  function automatic int unsigned frame_left();
    int unsigned w, h, n;
    w = eff_width();
    h = eff_height();
    n = (col_cnt >= w) ? 1 : w - col_cnt;
    if (row_cnt + 1 < h) n += (h - 1 - row_cnt) * w;
    return n;
  endfunction

  function automatic void conv_step(stim_item_t it);
    int unsigned  w, h, r, c;
    longint       acc;
    bit           ends_row, ends_frame;
    conv_result_t res;
    if (it.op == c2d_pkg::OP_WEIGHT) begin
      if (it.widx < TAPS) kern_w[it.widx] = it.wval;
      return;
    end
    w = eff_width();
    h = eff_height();
    r = row_cnt;
    c = col_cnt;
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    for (int ky = 0; ky < KDIM; ky++) begin
      for (int kx = 0; kx < KDIM - 1; kx++) win[ky][kx] = win[ky][kx+1];
    end
    for (int i = 0; i < LINES; i++) win[i][KDIM-1] = line_mem[i][c];
    win[KDIM-1][KDIM-1] = it.pix;
    for (int i = 0; i < LINES - 1; i++) line_mem[i][c] = line_mem[i+1][c];
    line_mem[LINES-1][c] = it.pix;
    ends_row   = (c + 1 >= w);
    ends_frame = ends_row && (r + 1 >= h);
    if (ends_row) begin
      col_cnt = 0;
      row_cnt = ends_frame ? 0 : ((r + 1) & 32'hFFF);
    end else begin
      col_cnt = c + 1;
    end
    if (r < LINES || c < LINES) return;
    acc = longint'(cfg_bias);
    for (int ky = 0; ky < KDIM; ky++) begin
      for (int kx = 0; kx < KDIM; kx++) begin
        acc += longint'(win[ky][kx]) * longint'(kern_w[ky*KDIM+kx]);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
    res.value = acc[VAL_W-1:0];
    res.row   = ROW_W'(r - LINES);
    res.col   = COL_W'(c - LINES);
    res.last  = ends_frame;
    conv_q.push_back(res);
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic push_weight(logic [WIDX_W-1:0] idx, logic [WGT_W-1:0] val);
    stim_item_t it;
    it.op   = c2d_pkg::OP_WEIGHT;
    it.widx = idx;
    it.wval = val;
    it.pix  = c2d_pkg::pixel_t'($urandom);
    item_q.push_back(it);
    items_sent++;
  endtask

  // n pixels (fixed value, or random with extremes when fixed_pix < 0),
  // with stray weight writes mixed in
  task automatic push_run(int n, int noise_pct, int fixed_pix);
    stim_item_t it;
    while (n > 0) begin
      if ($urandom_range(99) < noise_pct) begin
        push_weight(WIDX_W'($urandom_range(31)), WGT_W'($urandom));
      end else begin
        it.op   = c2d_pkg::OP_PIXEL;
        it.widx = WIDX_W'($urandom);
        it.wval = WGT_W'($urandom);
        if (fixed_pix >= 0) it.pix = c2d_pkg::pixel_t'(fixed_pix);
        else case ($urandom_range(9))
          0:       it.pix = '0;
          1:       it.pix = '1;
          default: it.pix = c2d_pkg::pixel_t'($urandom);
        endcase
        item_q.push_back(it);
        items_sent++;
        n--;
      end
    end
  endtask

  task automatic load_kernel(kern_fill_e fill);
    for (int i = 0; i < TAPS; i++) begin
      case (fill)
        KERN_MAX: push_weight(WIDX_W'(i), 16'h7FFF);
        KERN_MIN: push_weight(WIDX_W'(i), 16'h8000);
        default:  push_weight(WIDX_W'(i), WGT_W'($urandom));
      endcase
    end
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      c2d_pkg::CFG_WIDTH:  cfg_width  = data[IMG_WIDTH_W-1:0];
      c2d_pkg::CFG_HEIGHT: cfg_height = data[IMG_HEIGHT_W-1:0];
      c2d_pkg::CFG_BIAS:   cfg_bias   = data[BIAS_W-1:0];
      default: ;
    endcase
  endtask

  // all items taken, all results back, pipeline drained
  task automatic wait_idle();
    while (item_q.size() != 0 || n_given != n_taken || conv_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic finish_frame(int noise_pct);
    wait_idle();
    if (row_cnt == 0 && col_cnt == 0) return;
    // a tall frame is cut short by lowering the height mid-frame
    if (frame_left() > 600)
      reg_write(c2d_pkg::CFG_HEIGHT,
                CFG_DATA_W'((row_cnt + 1 < KDIM) ? KDIM : row_cnt + 1));
    push_run(frame_left(), noise_pct, -1);
    wait_idle();
  endtask

  task automatic rand_phase();
    int mode;
    int n;
    mode = $urandom_range(3);
    if (mode != 3) finish_frame(4);
    else wait_idle();
    if ($urandom_range(1)) begin
      case ($urandom_range(9))
        0:       reg_write(c2d_pkg::CFG_WIDTH, CFG_DATA_W'($urandom_range(4)));
        1:       reg_write(c2d_pkg::CFG_WIDTH, CFG_DATA_W'(MAX_WIDTH));
        2:       reg_write(c2d_pkg::CFG_WIDTH, CFG_DATA_W'($urandom_range(127, 65)));
        3:       reg_write(c2d_pkg::CFG_WIDTH, CFG_DATA_W'(KDIM));
        4:       reg_write(c2d_pkg::CFG_WIDTH, CFG_DATA_W'($urandom_range(63, 17)));
        default: reg_write(c2d_pkg::CFG_WIDTH, CFG_DATA_W'($urandom_range(16, 5)));
      endcase
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(11))
        0:       reg_write(c2d_pkg::CFG_HEIGHT, CFG_DATA_W'($urandom_range(4)));
        1:       reg_write(c2d_pkg::CFG_HEIGHT, CFG_DATA_W'(4095));
        2:       reg_write(c2d_pkg::CFG_HEIGHT, CFG_DATA_W'(KDIM));
        default: reg_write(c2d_pkg::CFG_HEIGHT, CFG_DATA_W'($urandom_range(9, 5)));
      endcase
    end
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(5))
        0:       reg_write(c2d_pkg::CFG_BIAS, 29'h0FFF_FFFF);
        1:       reg_write(c2d_pkg::CFG_BIAS, 29'h1000_0000);
        2:       reg_write(c2d_pkg::CFG_BIAS, '0);
        3, 4:    reg_write(c2d_pkg::CFG_BIAS,
                           29'(int'($urandom_range(4194304)) - 2097152));
        default: reg_write(c2d_pkg::CFG_BIAS, 29'($urandom));
      endcase
    end
    if ($urandom_range(7) == 0) load_kernel(KERN_RAND);
    if (mode == 3) begin
      push_run($urandom_range(120, 1), 5, -1);
    end else begin
      n = frame_left();
      if (n > 600) n = $urandom_range(300, 50);
      push_run(n, 5, -1);
    end
  endtask

  // input side: one item in flight, gaps at random
  always @(negedge clk_i) begin
    if (n_given == n_taken) begin
      if (rst_ni && item_q.size() != 0 && (no_idle || $urandom_range(99) >= 34)) begin
        cur_item = item_q.pop_front();
        n_given++;
        in_bus.valid        <= 1'b1;
        in_bus.operation    <= cur_item.op;
        in_bus.weight_index <= cur_item.widx;
        in_bus.weight_value <= cur_item.wval;
        in_bus.pixel        <= cur_item.pix;
      end else begin
        in_bus.valid        <= 1'b0;
        in_bus.operation    <= 1'($urandom);
        in_bus.weight_index <= WIDX_W'($urandom);
        in_bus.weight_value <= WGT_W'($urandom);
        in_bus.pixel        <= c2d_pkg::pixel_t'($urandom);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      conv_step(cur_item);
      n_taken++;
    end
  end

  // output side: random back-pressure
  always @(negedge clk_i) begin
    out_bus.ready <= no_idle || ($urandom_range(99) >= 34);
  end

  always @(posedge clk_i) begin
    conv_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (conv_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                  out_bus.out_row, out_bus.out_col, out_bus.conv_value));
      end else begin
        want = conv_q.pop_front();
        if (out_bus.conv_value !== want.value)
          report_mismatch($sformatf("row %0d col %0d: value %0d, expected %0d",
                                    want.row, want.col, out_bus.conv_value, want.value));
        if (out_bus.out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, expected %0d", out_bus.out_row, want.row));
        if (out_bus.out_col !== want.col)
          report_mismatch($sformatf("row %0d: out_col %0d, expected %0d",
                                    want.row, out_bus.out_col, want.col));
        if (out_bus.last !== want.last)
          report_mismatch($sformatf("row %0d col %0d: last %0b, expected %0b",
                                    want.row, want.col, out_bus.last, want.last));
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = c2d_pkg::CFG_WIDTH;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset sizes, largest weights; writes past the last tap must be dropped
    load_kernel(KERN_MAX);
    push_weight(5'd25, 16'h8000);
    push_weight(5'd31, 16'h8000);
    push_run(6 * 28, 0, -1);
    wait_idle();
    // height lowered below the row counter: the current row closes the frame
    reg_write(c2d_pkg::CFG_HEIGHT, CFG_DATA_W'(KDIM));
    finish_frame(0);

    // full width frame, largest sum, no gaps on either side;
    // also fills every line buffer entry
    reg_write(c2d_pkg::CFG_WIDTH, CFG_DATA_W'(MAX_WIDTH));
    reg_write(c2d_pkg::CFG_BIAS, 29'h0FFF_FFFF);
    no_idle = 1'b1;
    push_run(MAX_WIDTH * KDIM, 0, 255);
    wait_idle();
    no_idle = 1'b0;

    // most negative sum clips to zero; zero sizes clamp to the kernel
    reg_write(c2d_pkg::CFG_BIAS, 29'h1000_0000);
    reg_write(c2d_pkg::CFG_WIDTH, '0);
    reg_write(c2d_pkg::CFG_HEIGHT, '0);
    load_kernel(KERN_MIN);
    push_run(KDIM * KDIM, 0, 255);
    wait_idle();

    // oversize width, tallest height, cut short mid-frame
    reg_write(c2d_pkg::CFG_BIAS, '0);
    reg_write(c2d_pkg::CFG_WIDTH, CFG_DATA_W'(127));
    reg_write(c2d_pkg::CFG_HEIGHT, CFG_DATA_W'(4095));
    load_kernel(KERN_RAND);
    push_run(MAX_WIDTH * 6 + 10, 2, -1);
    finish_frame(0);

    while (items_sent < N_ITEMS) begin
      rand_phase();
    end
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
